### design/jpeg_exif_header_locator_top_assert.svh
// assertion macros for the exif header locator
`ifndef JPEG_EXIF_HEADER_LOCATOR_TOP_ASSERT_SVH
`define JPEG_EXIF_HEADER_LOCATOR_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define JEL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define JEL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/jel_pkg.sv
// shared types and constants of the exif header locator
package jel_pkg;

	// byte queue between classifier and parser
	localparam int unsigned FIFO_AW    = 2;
	localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;
	localparam int unsigned FIFO_CW    = FIFO_AW + 1;

	// marker and header constants
	localparam logic [7:0]  MRK_FF       = 8'hFF;
	localparam logic [7:0]  MRK_SOI      = 8'hD8;
	localparam logic [7:0]  MRK_SOS      = 8'hDA;
	localparam logic [7:0]  MRK_APP1     = 8'hE1;
	localparam logic [7:0]  ORDER_MOTO   = 8'h4D;
	localparam logic [15:0] TIFF_MAGIC   = 16'h002A;
	localparam logic [15:0] MIN_SEG_LEN  = 16'd2;
	localparam logic [15:0] APP1_MIN_LEN = 16'd8;
	localparam logic [2:0]  EXIF_SIG_LAST = 3'd5;

	// parser phases
	typedef enum logic [3:0] {
		PH_SOI0  = 4'd0,
		PH_SOI1  = 4'd1,
		PH_MFF   = 4'd2,
		PH_MCODE = 4'd3,
		PH_LHI   = 4'd4,
		PH_LLO   = 4'd5,
		PH_SKIP  = 4'd6,
		PH_MATCH = 4'd7,
		PH_TIFF  = 4'd8,
		PH_DONE  = 4'd9
	} phase_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SOI    = 3'd1,
		ST_BAD_MARK  = 3'd2,
		ST_SOS       = 3'd3,
		ST_END       = 3'd4,
		ST_BAD_MAGIC = 3'd5,
		ST_TRUNC     = 3'd6,
		ST_BAD_LEN   = 3'd7
	} status_t;

	// tiff header byte slots
	localparam logic [2:0] TH_ORDER0 = 3'd0;
	localparam logic [2:0] TH_ORDER1 = 3'd1;
	localparam logic [2:0] TH_MAGIC0 = 3'd2;
	localparam logic [2:0] TH_MAGIC1 = 3'd3;
	localparam logic [2:0] TH_IFD_LAST = 3'd7;

	// classified byte as queued between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_ff;
		logic       is_soi;
		logic       is_sos;
		logic       is_app1;
		logic       is_moto;
	} byte_cls_t;

	// queue status seen by the top level
	typedef struct packed {
		logic               full;
		logic               empty;
		logic [FIFO_CW-1:0] count;
	} fifo_stat_t;

	// "Exif" 00 00 signature
	function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h45;
			3'd1:    r = 8'h78;
			3'd2:    r = 8'h69;
			3'd3:    r = 8'h66;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### design/jel_byte_if.sv
// byte input channel
interface jel_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### design/jel_result_if.sv
// result output channel
interface jel_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] tiff_offset;
	logic        big_endian;
	logic [31:0] ifd0_offset;

	modport source (output valid, output status, output tiff_offset, output big_endian,
		output ifd0_offset, input ready);
	modport sink (input valid, input status, input tiff_offset, input big_endian,
		input ifd0_offset, output ready);
endinterface

### design/jel_front.sv
// front end: accepts bytes and tags them with marker flags
module jel_front import jel_pkg::*; (
	jel_byte_if.sink in_ch,
	input  logic      full,
	output logic      push,
	output byte_cls_t cls
);

	// accept while the queue has room
	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	// byte classification
	always_comb begin
		cls.data    = in_ch.data_byte;
		cls.last    = in_ch.last_byte;
		cls.is_ff   = (in_ch.data_byte == MRK_FF);
		cls.is_soi  = (in_ch.data_byte == MRK_SOI);
		cls.is_sos  = (in_ch.data_byte == MRK_SOS);
		cls.is_app1 = (in_ch.data_byte == MRK_APP1);
		cls.is_moto = (in_ch.data_byte == ORDER_MOTO);
	end

endmodule

### design/jel_fifo.sv
// short queue of classified bytes between front and back
module jel_fifo import jel_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  byte_cls_t  wr_data,
	input  logic       pop,
	output byte_cls_t  rd_data,
	output fifo_stat_t stat
);

	byte_cls_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FIFO_CW'(FIFO_DEPTH));

endmodule

### design/jel_back.sv
// back end: segment parser and result register
module jel_back import jel_pkg::*; #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  byte_cls_t cls,
	input  logic      avail,
	output logic      pop,
	jel_result_if.source res_ch
);

	phase_t                   phase_q, phase_d;
	logic [POSITION_BITS-1:0] pos_q;
	logic [15:0]              skip_q, skip_d;
	logic                     app1_q, app1_d;
	logic [7:0]               len_hi_q, len_hi_d;
	logic [2:0]               midx_q, midx_d;
	logic                     order_q, order_d;
	logic [31:0]              acc_q, acc_d;

	logic                     res_valid_q;
	status_t                  res_status_q;
	logic [31:0]              res_tiff_q;
	logic                     res_be_q;
	logic [31:0]              res_ifd_q;

	logic [15:0]              seg_len;
	logic [15:0]              skip_ld;
	logic [15:0]              skip_dec;
	logic                     sig_hit;
	logic [15:0]              acc16;
	logic [15:0]              magic;
	logic                     magic_bad;
	logic [31:0]              acc32;
	logic [31:0]              ifd_val;
	logic [POSITION_BITS-1:0] tiff_pos;

	logic                     step_emit;
	status_t                  step_status;
	logic                     emit;
	status_t                  emit_status;

	// parser consumes a byte when the result register can take an outcome
	assign pop = avail && (!res_valid_q || res_ch.ready);

	// shared datapath terms
	assign seg_len   = {len_hi_q, cls.data};
	assign skip_ld   = seg_len - MIN_SEG_LEN;
	assign skip_dec  = skip_q - 16'd1;
	assign sig_hit   = (cls.data == exif_sig_byte(midx_q));
	assign acc16     = {acc_q[7:0], cls.data};
	assign magic     = order_q ? acc16 : {acc16[7:0], acc16[15:8]};
	assign magic_bad = (magic != TIFF_MAGIC);
	assign acc32     = {acc_q[23:0], cls.data};
	assign ifd_val   = order_q ? acc32 : {acc32[7:0], acc32[15:8], acc32[23:16], acc32[31:24]};
	assign tiff_pos  = pos_q - POSITION_BITS'(7);

	// phase next state
	always_comb begin
		case (phase_q)
			PH_SOI0:  phase_d = cls.is_ff ? PH_SOI1 : PH_DONE;
			PH_SOI1:  phase_d = cls.is_soi ? PH_MFF : PH_DONE;
			PH_MFF:   phase_d = cls.is_ff ? PH_MCODE : PH_DONE;
			PH_MCODE: phase_d = cls.is_sos ? PH_DONE : PH_LHI;
			PH_LHI:   phase_d = PH_LLO;
			PH_LLO: begin
				if (seg_len < MIN_SEG_LEN) begin
					phase_d = PH_DONE;
				end else if (skip_ld == '0) begin
					phase_d = PH_MFF;
				end else if (app1_q && seg_len >= APP1_MIN_LEN) begin
					phase_d = PH_MATCH;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP:  phase_d = (skip_dec == '0) ? PH_MFF : PH_SKIP;
			PH_MATCH: begin
				if (sig_hit) begin
					phase_d = (midx_q == EXIF_SIG_LAST) ? PH_TIFF : PH_MATCH;
				end else begin
					phase_d = (skip_dec == '0) ? PH_MFF : PH_SKIP;
				end
			end
			PH_TIFF: begin
				if ((midx_q == TH_MAGIC1 && magic_bad) || midx_q == TH_IFD_LAST) begin
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_TIFF;
				end
			end
			default:  phase_d = PH_DONE;
		endcase
	end

	// per-byte datapath updates and outcomes
	always_comb begin
		skip_d      = skip_q;
		app1_d      = app1_q;
		len_hi_d    = len_hi_q;
		midx_d      = midx_q;
		order_d     = order_q;
		acc_d       = acc_q;
		step_emit   = 1'b0;
		step_status = ST_OK;
		case (phase_q)
			PH_SOI0, PH_SOI1: begin
				if ((phase_q == PH_SOI0 && !cls.is_ff) || (phase_q == PH_SOI1 && !cls.is_soi)) begin
					step_emit   = 1'b1;
					step_status = ST_NO_SOI;
				end
			end
			PH_MFF: begin
				if (!cls.is_ff) begin
					step_emit   = 1'b1;
					step_status = ST_BAD_MARK;
				end
			end
			PH_MCODE: begin
				if (cls.is_sos) begin
					step_emit   = 1'b1;
					step_status = ST_SOS;
				end else begin
					app1_d = cls.is_app1;
				end
			end
			PH_LHI: begin
				len_hi_d = cls.data;
			end
			PH_LLO: begin
				if (seg_len < MIN_SEG_LEN) begin
					step_emit   = 1'b1;
					step_status = ST_BAD_LEN;
				end else begin
					skip_d = skip_ld;
					midx_d = '0;
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
			end
			PH_MATCH: begin
				skip_d = skip_dec;
				if (sig_hit) begin
					if (midx_q == EXIF_SIG_LAST) begin
						midx_d  = '0;
						acc_d   = '0;
						order_d = 1'b0;
					end else begin
						midx_d = midx_q + 3'd1;
					end
				end
			end
			PH_TIFF: begin
				midx_d = midx_q + 3'd1;
				case (midx_q)
					TH_ORDER0: order_d = cls.is_moto;
					TH_ORDER1: order_d = order_q && cls.is_moto;
					TH_MAGIC0: acc_d   = {16'd0, acc16};
					TH_MAGIC1: begin
						if (magic_bad) begin
							step_emit   = 1'b1;
							step_status = ST_BAD_MAGIC;
						end else begin
							acc_d = '0;
						end
					end
					TH_IFD_LAST: begin
						acc_d       = acc32;
						step_emit   = 1'b1;
						step_status = ST_OK;
					end
					default:   acc_d = acc32;
				endcase
			end
			default: begin
			end
		endcase
	end

	// end of file without an earlier outcome
	always_comb begin
		emit        = step_emit;
		emit_status = step_status;
		if (cls.last && !step_emit && phase_q != PH_DONE) begin
			emit = 1'b1;
			if (phase_d == PH_SOI0 || phase_d == PH_SOI1) begin
				emit_status = ST_NO_SOI;
			end else if (phase_d == PH_TIFF) begin
				emit_status = ST_TRUNC;
			end else begin
				emit_status = ST_END;
			end
		end
	end

	// parser state, cleared after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SOI0;
			pos_q    <= '0;
			skip_q   <= '0;
			app1_q   <= 1'b0;
			len_hi_q <= '0;
			midx_q   <= '0;
			order_q  <= 1'b0;
			acc_q    <= '0;
		end else if (pop) begin
			if (cls.last) begin
				phase_q  <= PH_SOI0;
				pos_q    <= '0;
				skip_q   <= '0;
				app1_q   <= 1'b0;
				len_hi_q <= '0;
				midx_q   <= '0;
				order_q  <= 1'b0;
				acc_q    <= '0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_q + 1'b1;
				skip_q   <= skip_d;
				app1_q   <= app1_d;
				len_hi_q <= len_hi_d;
				midx_q   <= midx_d;
				order_q  <= order_d;
				acc_q    <= acc_d;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, fields other than status are zero on failure
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_status_q <= emit_status;
			if (step_emit && step_status == ST_OK) begin
				res_tiff_q <= 32'(tiff_pos);
				res_be_q   <= order_q;
				res_ifd_q  <= ifd_val;
			end else begin
				res_tiff_q <= '0;
				res_be_q   <= 1'b0;
				res_ifd_q  <= '0;
			end
		end
	end

	assign res_ch.valid       = res_valid_q;
	assign res_ch.status      = res_status_q;
	assign res_ch.tiff_offset = res_tiff_q;
	assign res_ch.big_endian  = res_be_q;
	assign res_ch.ifd0_offset = res_ifd_q;

endmodule

### design/jpeg_exif_header_locator_top.sv
// Exif header locator: takes a JPEG file one byte per transfer, walks its marker segments
// and reports once per file where the TIFF header of the first matching APP1 Exif segment
// sits, its byte order and its IFD0 offset, or a status code for why it stopped. A new byte
// is taken every cycle while the four-entry byte queue has room. The parser consumes one
// byte per cycle, set by its single state update per byte, and pauses only while an
// earlier result waits to be taken, which also bounds the sustained rate. A deciding byte
// passes through the byte queue, and its result is written to the output register when
// the parser consumes it. Further bytes after an outcome are consumed silently until the
// byte flagged last_byte, after which all state returns to the start of a new file.
module jpeg_exif_header_locator_top import jel_pkg::*; #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	jel_byte_if.sink     in_ch,
	jel_result_if.source res_ch
);

	`include "jpeg_exif_header_locator_top_assert.svh"

	logic       push;
	logic       pop;
	byte_cls_t  cls_in;
	byte_cls_t  cls_out;
	fifo_stat_t fifo_st;

	// classify incoming bytes
	jel_front u_front (
		.in_ch (in_ch),
		.full  (fifo_st.full),
		.push  (push),
		.cls   (cls_in)
	);

	// decouple front and parser
	jel_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls_in),
		.pop     (pop),
		.rd_data (cls_out),
		.stat    (fifo_st)
	);

	// segment parser and result register
	jel_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cls    (cls_out),
		.avail  (!fifo_st.empty),
		.pop    (pop),
		.res_ch (res_ch)
	);

	// queue bookkeeping checks
	`JEL_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_st.count <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
	`JEL_ASSERT_NOW(a_pop_nonempty, pop, !fifo_st.empty, "parser read an empty queue")
	`JEL_ASSERT_NEXT(a_push_lands, push && !pop, !fifo_st.empty, "pushed byte lost")

endmodule

### tb/testbench.sv
// self-checking testbench for the jpeg exif header locator: directed and random files
module testbench;
	import jel_pkg::*;

	// local marker codes used to build files
	localparam logic [7:0]  MRK_APP0    = 8'hE0;
	localparam logic [7:0]  MRK_SOF0    = 8'hC0;
	localparam logic [7:0]  MRK_RST0    = 8'hD0;
	localparam logic [7:0]  ORDER_INTEL = 8'h49;
	localparam logic [47:0] EXIF_TAG    = 48'h4578_6966_0000;
	localparam int          TAIL_CYCLES = 12;

	typedef struct packed {
		status_t     status;
		logic [31:0] tiff_offset;
		logic        big_endian;
		logic [31:0] ifd0_offset;
	} exif_report_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} file_byte_t;

	logic clk;
	logic arst_n;

	jel_byte_if   in_ch();
	jel_result_if res_ch();

	jpeg_exif_header_locator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.res_ch (res_ch)
	);

	// stimulus and expectation stores
	file_byte_t   byte_feed[$];
	logic [7:0]   file_buf[$];
	exif_report_t header_reports[$];
	file_byte_t   next_byte;
	logic         byte_taken;

	int errors;
	int files_built;
	int bytes_queued;
	int bytes_accepted;
	int results_seen;
	int headers_found;
	int send_gap_pct;
	int recv_stall_pct;

	// predictor state
	phase_t      loc_phase;
	logic [31:0] loc_pos;
	logic [15:0] loc_skip;
	logic [7:0]  loc_marker;
	logic [7:0]  loc_len_hi;
	logic [3:0]  loc_idx;
	logic        loc_big;
	logic [31:0] loc_acc;
	logic        loc_done;

	task automatic clear_locator();
		loc_phase  = PH_SOI0;
		loc_pos    = '0;
		loc_skip   = '0;
		loc_marker = '0;
		loc_len_hi = '0;
		loc_idx    = '0;
		loc_big    = 1'b0;
		loc_acc    = '0;
		loc_done   = 1'b0;
	endtask

	// one byte through the parser; pushes the report it decides, if any
	task automatic locate_step(input logic [7:0] b, input logic lst);
		exif_report_t r;
		logic         hit;
		logic [15:0]  seg_len;
		logic [15:0]  magic;
		logic [31:0]  ifd;
		r = '0;
		hit = 1'b0;
		case (loc_phase)
			PH_SOI0: begin
				if (b != MRK_FF) begin
					r.status = ST_NO_SOI;
					hit = 1'b1;
				end else
					loc_phase = PH_SOI1;
			end
			PH_SOI1: begin
				if (b != MRK_SOI) begin
					r.status = ST_NO_SOI;
					hit = 1'b1;
				end else
					loc_phase = PH_MFF;
			end
			PH_MFF: begin
				if (b != MRK_FF) begin
					r.status = ST_BAD_MARK;
					hit = 1'b1;
				end else
					loc_phase = PH_MCODE;
			end
			PH_MCODE: begin
				if (b == MRK_SOS) begin
					r.status = ST_SOS;
					hit = 1'b1;
				end else begin
					loc_marker = b;
					loc_phase = PH_LHI;
				end
			end
			PH_LHI: begin
				loc_len_hi = b;
				loc_phase = PH_LLO;
			end
			PH_LLO: begin
				seg_len = {loc_len_hi, b};
				if (seg_len < MIN_SEG_LEN) begin
					r.status = ST_BAD_LEN;
					hit = 1'b1;
				end else begin
					loc_skip = seg_len - MIN_SEG_LEN;
					if (loc_skip == 0)
						loc_phase = PH_MFF;
					else if (loc_marker == MRK_APP1 && seg_len >= APP1_MIN_LEN) begin
						loc_idx = '0;
						loc_phase = PH_MATCH;
					end else
						loc_phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				loc_skip = loc_skip - 1'b1;
				if (loc_skip == 0)
					loc_phase = PH_MFF;
			end
			PH_MATCH: begin
				loc_skip = loc_skip - 1'b1;
				if (loc_idx < 6 && b == EXIF_TAG[8*(5-loc_idx) +: 8]) begin
					loc_idx = loc_idx + 1'b1;
					if (loc_idx == 6) begin
						loc_idx = '0;
						loc_acc = '0;
						loc_big = 1'b0;
						loc_phase = PH_TIFF;
					end
				end else if (loc_skip == 0)
					loc_phase = PH_MFF;
				else
					loc_phase = PH_SKIP;
			end
			PH_TIFF: begin
				if (loc_idx == 0)
					loc_big = (b == ORDER_MOTO);
				else if (loc_idx == 1)
					loc_big = loc_big && (b == ORDER_MOTO);
				else if (loc_idx <= 3) begin
					loc_acc = {16'h0, loc_acc[7:0], b};
					if (loc_idx == 3) begin
						magic = loc_big ? loc_acc[15:0] : {loc_acc[7:0], loc_acc[15:8]};
						if (magic != TIFF_MAGIC) begin
							r.status = ST_BAD_MAGIC;
							hit = 1'b1;
						end else
							loc_acc = '0;
					end
				end else begin
					loc_acc = {loc_acc[23:0], b};
					if (loc_idx == 7) begin
						ifd = loc_big ? loc_acc :
							{loc_acc[7:0], loc_acc[15:8], loc_acc[23:16], loc_acc[31:24]};
						r.status = ST_OK;
						r.tiff_offset = loc_pos - 32'd7;
						r.big_endian = loc_big;
						r.ifd0_offset = ifd;
						hit = 1'b1;
					end
				end
				if (!hit)
					loc_idx = loc_idx + 1'b1;
			end
			default: ;
		endcase
		if (hit) begin
			loc_phase = PH_DONE;
			loc_done = 1'b1;
		end
		loc_pos = loc_pos + 1'b1;
		// end of file: report why nothing was found, then start over
		if (lst) begin
			if (!loc_done) begin
				r = '0;
				if (loc_phase == PH_SOI0 || loc_phase == PH_SOI1)
					r.status = ST_NO_SOI;
				else if (loc_phase == PH_TIFF)
					r.status = ST_TRUNC;
				else
					r.status = ST_END;
				hit = 1'b1;
			end
			clear_locator();
		end
		if (hit)
			header_reports.push_back(r);
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// compare one result transfer against the oldest expected report
	task automatic check_result();
		exif_report_t w;
		results_seen++;
		if (header_reports.size() == 0) begin
			report($sformatf("unexpected result, status %0d", res_ch.status));
		end else begin
			w = header_reports.pop_front();
			if (w.status == ST_OK)
				headers_found++;
			if (res_ch.status != w.status)
				report($sformatf("status %0d, want %0d", res_ch.status, w.status));
			if (res_ch.tiff_offset != w.tiff_offset)
				report($sformatf("tiff_offset %0h, want %0h", res_ch.tiff_offset,
					w.tiff_offset));
			if (res_ch.big_endian != w.big_endian)
				report($sformatf("big_endian %0b, want %0b", res_ch.big_endian,
					w.big_endian));
			if (res_ch.ifd0_offset != w.ifd0_offset)
				report($sformatf("ifd0_offset %0h, want %0h", res_ch.ifd0_offset,
					w.ifd0_offset));
		end
	endtask

	// file building helpers
	task automatic put(input logic [7:0] b);
		file_buf.push_back(b);
	endtask

	task automatic put_soi();
		put(MRK_FF);
		put(MRK_SOI);
	endtask

	task automatic put_seg(input logic [7:0] marker, input int body);
		logic [15:0] len;
		len = 16'(body + 2);
		put(MRK_FF);
		put(marker);
		put(len[15:8]);
		put(len[7:0]);
		repeat (body) put(8'($urandom));
	endtask

	// app1 exif segment; declared length of zero means the natural one
	task automatic put_exif(input logic [7:0] o0, input logic [7:0] o1, input logic good_magic,
		input int declared, input int extra, input logic [31:0] ifd);
		logic [15:0] len;
		logic [15:0] magic;
		logic        big;
		int          i;
		len = 16'((declared != 0) ? declared : 16 + extra);
		big = (o0 == ORDER_MOTO) && (o1 == ORDER_MOTO);
		magic = good_magic ? TIFF_MAGIC : (16'h0100 | 16'($urandom_range(0, 255)));
		put(MRK_FF);
		put(MRK_APP1);
		put(len[15:8]);
		put(len[7:0]);
		for (i = 0; i < 6; i++)
			put(EXIF_TAG[8*(5-i) +: 8]);
		put(o0);
		put(o1);
		if (big) begin
			put(magic[15:8]);
			put(magic[7:0]);
			for (i = 3; i >= 0; i--)
				put(ifd[8*i +: 8]);
		end else begin
			put(magic[7:0]);
			put(magic[15:8]);
			for (i = 0; i < 4; i++)
				put(ifd[8*i +: 8]);
		end
		repeat (extra) put(8'($urandom));
	endtask

	task automatic drop_tail(input int n);
		logic [7:0] scratch;
		repeat (n) scratch = file_buf.pop_back();
	endtask

	// move the built file to the byte feed, flagging its final byte
	task automatic ship();
		file_byte_t fb;
		int         i;
		for (i = 0; i < file_buf.size(); i++) begin
			fb.data = file_buf[i];
			fb.last = (i == file_buf.size() - 1);
			byte_feed.push_back(fb);
		end
		bytes_queued += file_buf.size();
		file_buf.delete();
		files_built++;
	endtask

	task automatic directed_files();
		// no soi: bad first byte with ignored trailer, lone ff, bad second byte
		put(8'h00);
		put(8'h11);
		ship();
		put(MRK_FF);
		ship();
		put(MRK_FF);
		put(8'hD9);
		put(8'hFF);
		ship();
		// located headers: motorola, intel ending on the last ifd byte, mixed order mark
		put_soi();
		put_seg(MRK_APP0, 2);
		put_exif(ORDER_MOTO, ORDER_MOTO, 1'b1, 0, 2, 32'h0000_0008);
		put(MRK_FF);
		put(MRK_SOS);
		ship();
		put_soi();
		put_exif(ORDER_INTEL, ORDER_INTEL, 1'b1, 0, 0, 32'hFFFF_FFFF);
		ship();
		put_soi();
		put_exif(ORDER_MOTO, ORDER_INTEL, 1'b1, 0, 1, 32'h0000_0000);
		ship();
		// bad magic in both orders
		put_soi();
		put_exif(ORDER_MOTO, ORDER_MOTO, 1'b0, 0, 0, $urandom);
		ship();
		put_soi();
		put_exif(ORDER_INTEL, ORDER_INTEL, 1'b0, 0, 0, $urandom);
		ship();
		// file ends inside the tiff header
		put_soi();
		put_exif(ORDER_MOTO, ORDER_MOTO, 1'b1, 0, 0, $urandom);
		drop_tail(5);
		ship();
		// file ends inside a segment body, and with the largest length
		put_soi();
		put_seg(MRK_SOF0, 8);
		drop_tail(4);
		ship();
		put_soi();
		put(MRK_FF);
		put(MRK_SOF0);
		put(8'hFF);
		put(8'hFF);
		put(8'h01);
		put(8'h02);
		ship();
		// start of scan, then a missing ff
		put_soi();
		put(MRK_FF);
		put(MRK_SOS);
		put(8'h00);
		ship();
		put_soi();
		put(8'h12);
		put(MRK_FF);
		ship();
		// segment lengths zero and one
		put_soi();
		put(MRK_FF);
		put(MRK_SOF0);
		put(8'h00);
		put(8'h00);
		ship();
		put_soi();
		put(MRK_FF);
		put(MRK_SOF0);
		put(8'h00);
		put(8'h01);
		put(MRK_FF);
		ship();
		// short app1 holding a partial signature is skipped
		put_soi();
		put(MRK_FF);
		put(MRK_APP1);
		put(8'h00);
		put(8'h07);
		put(EXIF_TAG[47:40]);
		put(EXIF_TAG[39:32]);
		put(EXIF_TAG[31:24]);
		put(EXIF_TAG[23:16]);
		put(EXIF_TAG[15:8]);
		put(MRK_FF);
		put(MRK_SOS);
		ship();
		// signature mismatches early and late, then a real exif segment
		put_soi();
		put(MRK_FF);
		put(MRK_APP1);
		put(8'h00);
		put(8'h0A);
		put(EXIF_TAG[47:40]);
		put(EXIF_TAG[39:32]);
		put(EXIF_TAG[31:24]);
		put(EXIF_TAG[39:32]);
		repeat (4) put(8'($urandom));
		put(MRK_FF);
		put(MRK_APP1);
		put(8'h00);
		put(8'h0A);
		put(EXIF_TAG[47:40]);
		put(EXIF_TAG[39:32]);
		put(EXIF_TAG[31:24]);
		put(EXIF_TAG[23:16]);
		put(8'h00);
		put(8'h01);
		repeat (2) put(8'($urandom));
		put_exif(ORDER_INTEL, ORDER_INTEL, 1'b1, 0, 0, $urandom);
		ship();
		// tiff header read past a declared length of eight
		put_soi();
		put_exif(ORDER_MOTO, ORDER_MOTO, 1'b1, 8, 3, $urandom);
		ship();
		// ff as marker code with empty body, a standalone marker with a length
		put_soi();
		put(MRK_FF);
		put(MRK_FF);
		put(8'h00);
		put(8'h02);
		put_seg(MRK_RST0, 1);
		put_exif(ORDER_INTEL, ORDER_INTEL, 1'b1, 0, 0, $urandom);
		put(MRK_FF);
		ship();
	endtask

	// mostly well-formed files with random content, some noise and damage
	task automatic make_random_file();
		int         kind;
		int         cut;
		int         pick;
		logic [7:0] mk;
		logic [7:0] o0;
		logic [7:0] o1;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 12))
				put($urandom_range(0, 1) ? MRK_FF : 8'($urandom));
		end else begin
			put_soi();
			repeat ($urandom_range(0, 3)) begin
				mk = 8'($urandom);
				if (mk == MRK_SOS)
					mk = MRK_APP0;
				put_seg(mk, $urandom_range(0, 10));
			end
			if ($urandom_range(0, 99) < 80) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					o0 = 8'($urandom);
					o1 = 8'($urandom);
				end else if (pick <= 5) begin
					o0 = ORDER_MOTO;
					o1 = ORDER_MOTO;
				end else begin
					o0 = ORDER_INTEL;
					o1 = ORDER_INTEL;
				end
				put_exif(o0, o1, $urandom_range(0, 99) < 85,
					($urandom_range(0, 9) == 0) ? 8 : 0, $urandom_range(0, 4), $urandom);
			end
			repeat ($urandom_range(0, 6)) put(8'($urandom));
			if ($urandom_range(0, 1)) begin
				put(MRK_FF);
				put(MRK_SOS);
			end
			if (kind < 28)
				file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom);
			else if (kind < 40) begin
				cut = $urandom_range(1, file_buf.size());
				drop_tail(file_buf.size() - cut);
			end
		end
		ship();
	endtask

	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || header_reports.size() != 0)
			@(negedge clk);
	endtask

	// clock and reset level from time zero
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		forever #5 clk = ~clk;
	end

	// byte driver, fed from the byte queue
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= '0;
			in_ch.last_byte <= 1'b0;
		end else if (!in_ch.valid || byte_taken) begin
			if (byte_feed.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				next_byte = byte_feed.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= next_byte.data;
				in_ch.last_byte <= next_byte.last;
			end else
				in_ch.valid <= 1'b0;
		end
	end

	// result receiver with random stalls
	always @(negedge clk)
		res_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);

	// monitor: check result transfers, predict from byte transfers
	always @(posedge clk) begin
		if (!arst_n)
			byte_taken <= 1'b0;
		else begin
			byte_taken <= in_ch.valid && in_ch.ready;
			if (res_ch.valid && res_ch.ready)
				check_result();
			if (in_ch.valid && in_ch.ready) begin
				bytes_accepted++;
				locate_step(in_ch.data_byte, in_ch.last_byte);
			end
		end
	end

	// stimulus phases and verdict
	initial begin
		int stage;
		int start_bytes;
		int start_files;
		errors = 0;
		files_built = 0;
		bytes_queued = 0;
		bytes_accepted = 0;
		results_seen = 0;
		headers_found = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		clear_locator();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (stage = 0; stage < 4; stage++) begin
			case (stage)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 51;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 51;
				end
				default: begin
					send_gap_pct = 24;
					recv_stall_pct = 24;
				end
			endcase
			if (stage == 0)
				directed_files();
			start_bytes = bytes_queued;
			start_files = files_built;
			while (bytes_queued - start_bytes < 100 || files_built - start_files < 3)
				make_random_file();
			wait_drained();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d files (%0d bytes) over four handshake pressure stages", files_built,
			bytes_accepted);
		$display("checked %0d results, %0d of them with a located tiff header", results_seen,
			headers_found);
		if (errors == 0 && header_reports.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("run limit reached with %0d reports outstanding", header_reports.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/jel_pkg.sv
design/jel_byte_if.sv
design/jel_result_if.sv
design/jel_front.sv
design/jel_fifo.sv
design/jel_back.sv
design/jpeg_exif_header_locator_top.sv
tb/testbench.sv
